@@ rtl/rpdc_pkg.sv @@
// shared constants, types and helpers of the record/play drift compensator
package rpdc_pkg;

  localparam int unsigned POS_W          = 18;
  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned RATE_W         = 18;
  localparam int unsigned LAT_W          = 32;
  localparam int unsigned RING_W         = 19;
  localparam int unsigned CFG_DW         = 19;
  localparam int unsigned CFG_AW         = 3;
  localparam int unsigned IN_DW          = 40;
  localparam int unsigned IN_UW          = 1;
  localparam int unsigned OUT_DW         = 56;
  localparam int unsigned OUT_UW         = 4;

  localparam logic [POS_W-1:0]  POS_MAX       = '1;
  localparam logic [RATE_W-1:0] RATE_MAX      = '1;
  localparam logic [POS_W-1:0]  NATIVE_RST    = 18'd48000;
  localparam logic [POS_W-1:0]  TARGET_RST    = 18'd2400;
  localparam logic [POS_W-1:0]  BAND_RST      = 18'd48;
  localparam logic [RING_W-1:0] RING_RST      = 19'd48000;

  localparam int unsigned RATE_DIV   = 50;
  localparam int unsigned RECIP_SH   = 24;
  localparam int unsigned RATE_RECIP = ((1 << RECIP_SH) + RATE_DIV - 1) / RATE_DIV;
  localparam int unsigned RECIP_W    = 19;
  localparam int unsigned STEP_W     = 13;
  localparam logic [STEP_W-1:0] STEP_RST = 13'd960;

  localparam int unsigned SMOOTH_SH = 15;
  localparam int unsigned ACC_W     = 49;
  localparam logic signed [ACC_W-1:0] SMOOTH_TAKE = 49'sd983;

  localparam logic signed [LAT_W-1:0] LAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [LAT_W-1:0] LAT_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_AW-1:0] {
    REG_ENABLE = 3'd0,
    REG_NATIVE = 3'd1,
    REG_TARGET = 3'd2,
    REG_BAND   = 3'd3,
    REG_RING   = 3'd4
  } cfg_reg_t;

  // position advance around the ring, saturated to the position width
  function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] pos,
                                               input logic [POS_W-1:0] last,
                                               input logic [RING_W-1:0] ring);
    logic [RING_W:0] up;
    logic [RING_W:0] d;
    up = (RING_W+1)'(pos) + (RING_W+1)'(ring);
    if (pos >= last) begin
      d = (RING_W+1)'(pos) - (RING_W+1)'(last);
    end else if (up < (RING_W+1)'(last)) begin
      d = '0;
    end else begin
      d = up - (RING_W+1)'(last);
    end
    return (d > (RING_W+1)'(POS_MAX)) ? POS_MAX : d[POS_W-1:0];
  endfunction

endpackage

@@ rtl/record_play_drift_compensator.sv @@
// top level of the record/play drift compensator
// an accepted poll is registered in s1_*_r, then s2_r, then the out_t* outputs
// throughput: one poll per cycle unless out_tready stalls it; stage a holds the
//   positions and totals, stage b the smoothed latency loop: one multiply by 983
// reset: rst_n low at a clock edge clears the pipeline and loads the register
//   and state reset values; no clearing pass is needed
module record_play_drift_compensator #(
  parameter int unsigned COUNT_BITS = rpdc_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rpdc_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [rpdc_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // record_position, play_position, zero fill
  input  logic [rpdc_pkg::IN_DW-1:0]    in_tdata,
  // recording_active
  input  logic [rpdc_pkg::IN_UW-1:0]    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // playback_rate, latency_estimate, zero fill
  output logic [rpdc_pkg::OUT_DW-1:0]   out_tdata,
  // start_playback, playing, paused, rate_valid
  output logic [rpdc_pkg::OUT_UW-1:0]   out_tuser
);

  localparam int unsigned PW = rpdc_pkg::POS_W;
  localparam int unsigned LW = rpdc_pkg::LAT_W;
  localparam int unsigned DW = (COUNT_BITS > LW) ? COUNT_BITS : LW + 1;

  typedef struct packed {
    logic                 calc;
    logic                 start;
    logic                 playing;
    logic                 paused;
    logic signed [LW-1:0] lat;
    logic [PW-1:0]        adj;
  } stage_t;

  // configuration
  logic                             enable_r;
  logic [PW-1:0]                    native_r;
  logic [rpdc_pkg::STEP_W-1:0]      step_r;
  logic [PW-1:0]                    target_r;
  logic [PW-1:0]                    band_r;
  logic [rpdc_pkg::RING_W-1:0]      ring_r;
  logic [PW+rpdc_pkg::RECIP_W-1:0]  step_prod;
  logic                             target_wr;

  // pipeline control
  logic rdy_o, rdy2, fire_in, fire1, fire2;
  logic v1_r, v2_r, ov_r;

  // stage 1 input register
  logic [PW-1:0] s1_rpos_r, s1_ppos_r;
  logic          s1_rec_r;

  // stage a state
  logic [PW-1:0]         last_rec_r, last_play_r, small_r, adj_r;
  logic [COUNT_BITS-1:0] rec_tot_r, play_tot_r;
  logic                  playing_r, paused_r;

  logic [PW-1:0]                rd, pd, adj_a;
  logic [COUNT_BITS-1:0]        rec_tot_a, play_tot_a;
  logic                         take, start_a, playing_a, paused_a;
  logic signed [COUNT_BITS-1:0] diff_a;
  logic signed [DW-1:0]         diff_x;
  logic signed [LW-1:0]         lat_a;
  stage_t                       s2_nxt, s2_r;

  // stage b state
  logic signed [LW-1:0]                smooth_r, smooth_b, lat_out;
  logic signed [LW:0]                  dlt;
  logic signed [rpdc_pkg::ACC_W-1:0]   acc, quo;
  logic signed [PW+1:0]                lo, hi;
  logic [PW:0]                         rate_up;
  logic [rpdc_pkg::RATE_W-1:0]         rate_b;

  assign rdy_o     = !ov_r || out_tready;
  assign rdy2      = !v2_r || rdy_o;
  assign in_tready = !v1_r || rdy2;
  assign fire_in   = in_tvalid && in_tready;
  assign fire1     = v1_r && rdy2;
  assign fire2     = v2_r && rdy_o;

  assign target_wr = cfg_we && (cfg_addr == rpdc_pkg::REG_TARGET);
  assign step_prod = (PW+rpdc_pkg::RECIP_W)'(cfg_wdata[PW-1:0])
                   * (PW+rpdc_pkg::RECIP_W)'(rpdc_pkg::RATE_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      native_r <= rpdc_pkg::NATIVE_RST;
      step_r   <= rpdc_pkg::STEP_RST;
      target_r <= rpdc_pkg::TARGET_RST;
      band_r   <= rpdc_pkg::BAND_RST;
      ring_r   <= rpdc_pkg::RING_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        rpdc_pkg::REG_ENABLE: enable_r <= cfg_wdata[0];
        rpdc_pkg::REG_NATIVE: begin
          native_r <= cfg_wdata[PW-1:0];
          step_r   <= step_prod[rpdc_pkg::RECIP_SH +: rpdc_pkg::STEP_W];
        end
        rpdc_pkg::REG_TARGET: target_r <= cfg_wdata[PW-1:0];
        rpdc_pkg::REG_BAND:   band_r   <= cfg_wdata[PW-1:0];
        rpdc_pkg::REG_RING:   ring_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (fire_in) begin
        v1_r <= 1'b1;
      end else if (fire1) begin
        v1_r <= 1'b0;
      end
      if (fire1) begin
        v2_r <= 1'b1;
      end else if (fire2) begin
        v2_r <= 1'b0;
      end
      if (fire2) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire_in) begin
      s1_rpos_r <= in_tdata[PW-1:0];
      s1_ppos_r <= in_tdata[2*PW-1:PW];
      s1_rec_r  <= in_tuser[0];
    end
  end

  // stage a: advances, totals, start and pause, measured latency
  always_comb begin
    rd        = rpdc_pkg::advance(s1_rpos_r, last_rec_r, ring_r);
    rec_tot_a = rec_tot_r + COUNT_BITS'(rd);
    take      = (rd != '0) && (rd < small_r);
    adj_a     = adj_r;
    if (take) begin
      adj_a = (rd <= target_r) ? target_r : rd;
    end
    start_a    = !playing_r && (rec_tot_a >= COUNT_BITS'(adj_a));
    playing_a  = playing_r || start_a;
    paused_a   = paused_r || (playing_a && !s1_rec_r);
    pd         = rpdc_pkg::advance(s1_ppos_r, last_play_r, ring_r);
    play_tot_a = playing_a ? (play_tot_r + COUNT_BITS'(pd)) : play_tot_r;
    diff_a     = $signed(rec_tot_a - play_tot_a);
    diff_x     = DW'(diff_a);
    if (diff_x > DW'(rpdc_pkg::LAT_MAX)) begin
      lat_a = rpdc_pkg::LAT_MAX;
    end else if (diff_x < DW'(rpdc_pkg::LAT_MIN)) begin
      lat_a = rpdc_pkg::LAT_MIN;
    end else begin
      lat_a = diff_x[LW-1:0];
    end
    s2_nxt.calc    = enable_r && playing_a;
    s2_nxt.start   = enable_r && start_a;
    s2_nxt.playing = enable_r ? playing_a : playing_r;
    s2_nxt.paused  = enable_r ? paused_a : paused_r;
    s2_nxt.lat     = lat_a;
    s2_nxt.adj     = enable_r ? adj_a : adj_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_rec_r  <= '0;
      last_play_r <= '0;
      rec_tot_r   <= '0;
      play_tot_r  <= '0;
      small_r     <= rpdc_pkg::POS_MAX;
      adj_r       <= rpdc_pkg::TARGET_RST;
      playing_r   <= 1'b0;
      paused_r    <= 1'b0;
    end else if (target_wr) begin
      adj_r <= cfg_wdata[PW-1:0];
    end else if (fire1 && enable_r) begin
      last_rec_r <= s1_rpos_r;
      rec_tot_r  <= rec_tot_a;
      adj_r      <= adj_a;
      playing_r  <= playing_a;
      paused_r   <= paused_a;
      if (take) begin
        small_r <= rd;
      end
      if (playing_a) begin
        last_play_r <= s1_ppos_r;
        play_tot_r  <= play_tot_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire1) begin
      s2_r <= s2_nxt;
    end
  end

  // stage b: 31785*s + 983*l written as 32768*s + 983*(l - s), truncated toward zero
  always_comb begin
    dlt = (LW+1)'(s2_r.lat) - (LW+1)'(smooth_r);
    acc = (rpdc_pkg::ACC_W'(smooth_r) <<< rpdc_pkg::SMOOTH_SH)
        + rpdc_pkg::ACC_W'(dlt) * rpdc_pkg::SMOOTH_TAKE;
    quo = acc >>> rpdc_pkg::SMOOTH_SH;
    if (acc[rpdc_pkg::ACC_W-1] && (acc[rpdc_pkg::SMOOTH_SH-1:0] != '0)) begin
      quo = quo + rpdc_pkg::ACC_W'(1);
    end
    smooth_b = quo[LW-1:0];
    lo       = $signed({2'b00, s2_r.adj}) - $signed({2'b00, band_r});
    hi       = $signed({2'b00, s2_r.adj}) + $signed({2'b00, band_r});
    rate_up  = (PW+1)'(native_r) + (PW+1)'(step_r);
    if ((LW+1)'(smooth_b) < (LW+1)'(lo)) begin
      rate_b = native_r - PW'(step_r);
    end else if ((LW+1)'(smooth_b) > (LW+1)'(hi)) begin
      rate_b = rate_up[PW] ? rpdc_pkg::RATE_MAX : rate_up[PW-1:0];
    end else begin
      rate_b = native_r;
    end
    lat_out = s2_r.calc ? smooth_b : smooth_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= LW'(rpdc_pkg::TARGET_RST);
    end else if (target_wr) begin
      smooth_r <= LW'(cfg_wdata[PW-1:0]);
    end else if (fire2 && s2_r.calc) begin
      smooth_r <= smooth_b;
    end
  end

  always_ff @(posedge clk) begin
    if (fire2) begin
      out_tdata <= {{(rpdc_pkg::OUT_DW-rpdc_pkg::RATE_W-LW){1'b0}}, lat_out,
                    s2_r.calc ? rate_b : {rpdc_pkg::RATE_W{1'b0}}};
      out_tuser <= {s2_r.calc, s2_r.paused, s2_r.playing, s2_r.start};
    end
  end

  assign out_tvalid = ov_r;

endmodule

@@ rtl/rpdc_checker.sv @@
// port-level checker of the record/play drift compensator and its bind
module rpdc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [rpdc_pkg::OUT_DW-1:0] out_tdata,
  input logic [rpdc_pkg::OUT_UW-1:0] out_tuser
);

  // stalled result transaction stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_start_playing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[1])
    else $error("start without playing");

  a_rate_playing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> out_tuser[1])
    else $error("rate valid while not playing");

  a_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[3] |-> out_tdata[rpdc_pkg::RATE_W-1:0] == '0)
    else $error("rate nonzero without rate valid");

  // the sticky paused flag is only shown together with playing
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1])
    else $error("paused while not playing");

endmodule

bind record_play_drift_compensator rpdc_checker u_rpdc_checker (.*);

@@ tb/tb.sv @@
// self-checking testbench of the record/play drift compensator
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POS_W  = rpdc_pkg::POS_W;
  localparam int unsigned RATE_W = rpdc_pkg::RATE_W;
  localparam int unsigned LAT_W  = rpdc_pkg::LAT_W;
  localparam int unsigned RING_W = rpdc_pkg::RING_W;
  localparam int unsigned CFG_DW = rpdc_pkg::CFG_DW;
  localparam int unsigned CFG_AW = rpdc_pkg::CFG_AW;
  localparam int unsigned IN_DW  = rpdc_pkg::IN_DW;
  localparam int unsigned IN_UW  = rpdc_pkg::IN_UW;
  localparam int unsigned OUT_DW = rpdc_pkg::OUT_DW;
  localparam int unsigned OUT_UW = rpdc_pkg::OUT_UW;

  localparam logic [POS_W-1:0]  POS_MAX    = rpdc_pkg::POS_MAX;
  localparam logic [RATE_W-1:0] RATE_MAX   = rpdc_pkg::RATE_MAX;
  localparam logic [POS_W-1:0]  NATIVE_RST = rpdc_pkg::NATIVE_RST;
  localparam logic [POS_W-1:0]  TARGET_RST = rpdc_pkg::TARGET_RST;
  localparam logic [POS_W-1:0]  BAND_RST   = rpdc_pkg::BAND_RST;
  localparam logic [RING_W-1:0] RING_RST   = rpdc_pkg::RING_RST;
  localparam longint            RATE_DIV   = longint'(rpdc_pkg::RATE_DIV);

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 4;
  localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic                     start;
    logic                     playing;
    logic                     paused;
    logic                     rate_valid;
    logic [RATE_W-1:0]        rate;
    logic signed [LAT_W-1:0]  latency;
  } drift_result_t;

  typedef struct packed {
    logic [POS_W-1:0] rec_pos;
    logic [POS_W-1:0] play_pos;
    logic             rec_on;
  } poll_t;

  typedef struct packed {
    logic              is_write;
    logic [CFG_AW-1:0] addr;
    logic [CFG_DW-1:0] wdata;
    poll_t             poll;
    logic              fixed;
    drift_result_t     want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;
  logic [IN_UW-1:0]  in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic [OUT_UW-1:0] out_tuser;

  record_play_drift_compensator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // predictor state
  logic              m_enable;
  logic [POS_W-1:0]  m_native;
  logic [POS_W-1:0]  m_target;
  logic [POS_W-1:0]  m_band;
  logic [RING_W-1:0] m_ring;
  logic [POS_W-1:0]  m_last_rec;
  logic [POS_W-1:0]  m_last_play;
  logic [31:0]       m_rec_total;
  logic [31:0]       m_play_total;
  logic [POS_W-1:0]  m_smallest;
  logic [POS_W-1:0]  m_adj;
  longint            m_smooth;
  logic              m_playing;
  logic              m_paused;

  drift_result_t rate_reports[$];
  int            fail_count = 0;
  int            snd_idle = 25;
  int            rcv_idle = 68;
  int            hold_ask = 0;
  int            hold_seen = 0;
  int            hold_left = 0;
  int            idle_cycles = 0;
  longint        gen_rec = 0;
  longint        gen_play = 0;
  longint        play_bias = 0;

  function automatic logic [POS_W-1:0] ring_advance(logic [POS_W-1:0] pos,
                                                    logic [POS_W-1:0] last);
    longint up;
    longint d;
    up = longint'(pos) + longint'(m_ring);
    if (pos >= last) begin
      d = longint'(pos) - longint'(last);
    end else if (up < longint'(last)) begin
      d = 0;
    end else begin
      d = up - longint'(last);
    end
    if (d > longint'(POS_MAX)) begin
      d = longint'(POS_MAX);
    end
    return POS_W'(d);
  endfunction

  function automatic void apply_reg(logic [CFG_AW-1:0] a, logic [CFG_DW-1:0] d);
    case (a)
      rpdc_pkg::REG_ENABLE: m_enable = d[0];
      rpdc_pkg::REG_NATIVE: m_native = d[POS_W-1:0];
      rpdc_pkg::REG_TARGET: begin
        m_target = d[POS_W-1:0];
        m_adj    = d[POS_W-1:0];
        m_smooth = longint'(d[POS_W-1:0]);
      end
      rpdc_pkg::REG_BAND:   m_band = d[POS_W-1:0];
      rpdc_pkg::REG_RING:   m_ring = d[RING_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic drift_result_t predict_poll(poll_t p);
    drift_result_t r;
    logic [POS_W-1:0] rd;
    logic [POS_W-1:0] pd;
    logic [31:0] diff;
    longint lat;
    longint acc;
    longint lo;
    longint hi;
    longint rate;
    r = '0;
    rate = 0;
    if (m_enable) begin
      rd = ring_advance(p.rec_pos, m_last_rec);
      m_last_rec = p.rec_pos;
      m_rec_total = m_rec_total + 32'(rd);
      if (rd != 0 && rd < m_smallest) begin
        m_smallest = rd;
        m_adj = (rd <= m_target) ? m_target : rd;
      end
      if (!m_playing && m_rec_total >= 32'(m_adj)) begin
        m_playing = 1'b1;
        r.start = 1'b1;
      end
      if (m_playing) begin
        if (!p.rec_on) begin
          m_paused = 1'b1;
        end
        pd = ring_advance(p.play_pos, m_last_play);
        m_last_play = p.play_pos;
        m_play_total = m_play_total + 32'(pd);
        diff = m_rec_total - m_play_total;
        lat = longint'(signed'(diff));
        acc = 64'sd31785 * m_smooth + 64'sd983 * lat;
        m_smooth = acc / 64'sd32768;
        lo = longint'(m_adj) - longint'(m_band);
        hi = longint'(m_adj) + longint'(m_band);
        rate = longint'(m_native);
        if (m_smooth < lo) begin
          rate = longint'(m_native) - longint'(m_native) / RATE_DIV;
        end else if (m_smooth > hi) begin
          rate = longint'(m_native) + longint'(m_native) / RATE_DIV;
        end
        if (rate > longint'(RATE_MAX)) begin
          rate = longint'(RATE_MAX);
        end
        r.rate_valid = 1'b1;
      end
    end
    r.playing = m_playing;
    r.paused  = m_paused;
    r.rate    = RATE_W'(rate);
    r.latency = LAT_W'(m_smooth);
    return r;
  endfunction

  function automatic drift_result_t outcome(logic s, logic pl, logic pa, logic v,
                                            logic [RATE_W-1:0] rate,
                                            logic signed [LAT_W-1:0] lat);
    drift_result_t r;
    r.start = s;
    r.playing = pl;
    r.paused = pa;
    r.rate_valid = v;
    r.rate = rate;
    r.latency = lat;
    return r;
  endfunction

  function automatic stim_row_t row_write(logic [CFG_AW-1:0] a, logic [CFG_DW-1:0] d);
    stim_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.addr = a;
    r.wdata = d;
    return r;
  endfunction

  function automatic stim_row_t row_poll(logic [POS_W-1:0] rp, logic [POS_W-1:0] pp,
                                         logic on);
    stim_row_t r;
    r = '0;
    r.poll.rec_pos = rp;
    r.poll.play_pos = pp;
    r.poll.rec_on = on;
    return r;
  endfunction

  function automatic stim_row_t row_known(logic [POS_W-1:0] rp, logic [POS_W-1:0] pp,
                                          logic on, drift_result_t w);
    stim_row_t r;
    r = row_poll(rp, pp, on);
    r.fixed = 1'b1;
    r.want = w;
    return r;
  endfunction

  task automatic write_reg(logic [CFG_AW-1:0] a, logic [CFG_DW-1:0] d);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= d;
    @(posedge clk);
    apply_reg(a, d);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (rate_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_poll(poll_t p, logic fixed, drift_result_t want);
    drift_result_t r;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, p.play_pos, p.rec_pos};
    in_tuser  <= p.rec_on;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = predict_poll(p);
    rate_reports.push_back(fixed ? want : r);
  endtask

  task automatic run_random(int n, bit pause_ok);
    poll_t p;
    longint ring;
    longint step;
    longint pstep;
    longint lat_now;
    logic [31:0] diff;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) begin
        play_bias = longint'($urandom_range(0, 6)) - 3;
      end
      ring = (m_ring == 0) ? 1 : longint'(m_ring);
      if ($urandom_range(0, 99) < 8) begin
        p.rec_pos  = POS_W'($urandom);
        p.play_pos = POS_W'($urandom);
        p.rec_on   = pause_ok ? 1'($urandom_range(0, 1)) : 1'b1;
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          step = longint'($urandom_range(0, 32'(ring - 1)));
        end else begin
          step = longint'($urandom_range(0, 64));
        end
        diff = m_rec_total - m_play_total;
        lat_now = longint'(signed'(diff));
        pstep = step + play_bias + (lat_now + step - longint'(m_adj)) / 32;
        if (pstep < 0) pstep = 0;
        if (pstep >= ring) pstep = ring - 1;
        gen_rec  = (gen_rec + step) % ring;
        gen_play = (gen_play + pstep) % ring;
        p.rec_pos  = POS_W'(gen_rec);
        p.play_pos = POS_W'(gen_play);
        p.rec_on   = !(pause_ok && $urandom_range(0, 299) == 0);
      end
      push_poll(p, 1'b0, '0);
    end
  endtask

  task automatic note_mismatch(string field, longint want, longint got);
    $display("%0t %s expected %0d actual %0d", $time, field, want, got);
    fail_count++;
  endtask

  task automatic check_result(drift_result_t got);
    drift_result_t want;
    if (rate_reports.size() == 0) begin
      $display("%0t unexpected transaction expected none actual rate %0d latency %0d",
               $time, got.rate, got.latency);
      fail_count++;
    end else begin
      want = rate_reports.pop_front();
      if (got.start != want.start)
        note_mismatch("start_playback", want.start, got.start);
      if (got.playing != want.playing)
        note_mismatch("playing", want.playing, got.playing);
      if (got.paused != want.paused)
        note_mismatch("paused", want.paused, got.paused);
      if (got.rate_valid != want.rate_valid)
        note_mismatch("rate_valid", want.rate_valid, got.rate_valid);
      if (got.rate != want.rate)
        note_mismatch("playback_rate", want.rate, got.rate);
      if (got.latency != want.latency)
        note_mismatch("latency_estimate", longint'(want.latency), longint'(got.latency));
    end
  endtask

  // result side: check and backpressure
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      check_result(outcome(out_tuser[0], out_tuser[1], out_tuser[2], out_tuser[3],
                           out_tdata[RATE_W-1:0], out_tdata[RATE_W+LAT_W-1:RATE_W]));
    end
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    m_enable = 1'b0;
    m_native = NATIVE_RST;
    m_target = TARGET_RST;
    m_band = BAND_RST;
    m_ring = RING_RST;
    m_last_rec = '0;
    m_last_play = '0;
    m_rec_total = '0;
    m_play_total = '0;
    m_smallest = POS_MAX;
    m_adj = TARGET_RST;
    m_smooth = longint'(TARGET_RST);
    m_playing = 1'b0;
    m_paused = 1'b0;

    rows.push_back(row_known(18'h3FFFF, 18'h3FFFF, 1'b0,
                             outcome(1'b0, 1'b0, 1'b0, 1'b0, 18'd0, 32'sd2400)));
    rows.push_back(row_known(18'h0, 18'h0, 1'b1,
                             outcome(1'b0, 1'b0, 1'b0, 1'b0, 18'd0, 32'sd2400)));
    rows.push_back(row_write(rpdc_pkg::REG_ENABLE, 19'd1));
    rows.push_back(row_write(rpdc_pkg::REG_TARGET, 19'd100));
    rows.push_back(row_known(18'h0, 18'h0, 1'b1,
                             outcome(1'b0, 1'b0, 1'b0, 1'b0, 18'd0, 32'sd100)));
    rows.push_back(row_known(18'h3FFFF, 18'h0, 1'b1,
                             outcome(1'b1, 1'b1, 1'b0, 1'b1, 18'd48960, 32'sd7960)));
    // ring too short to wrap, then smallest advance, then a zero advance
    rows.push_back(row_poll(18'd5, 18'h3FFFF, 1'b1));
    rows.push_back(row_poll(18'd10, 18'h3FFFF, 1'b1));
    rows.push_back(row_poll(18'd10, 18'h3FFFF, 1'b1));
    rows.push_back(row_poll(18'd9, 18'd20, 1'b1));
    rows.push_back(row_write(rpdc_pkg::REG_NATIVE, 19'd192000));
    rows.push_back(row_write(rpdc_pkg::REG_BAND, 19'd0));
    rows.push_back(row_poll(18'd100, 18'd60, 1'b1));
    rows.push_back(row_poll(18'd150, 18'd200, 1'b1));
    rows.push_back(row_write(rpdc_pkg::REG_NATIVE, 19'd8000));
    rows.push_back(row_write(rpdc_pkg::REG_BAND, 19'h3FFFF));
    rows.push_back(row_poll(18'd200, 18'd250, 1'b1));
    // rate saturation
    rows.push_back(row_write(rpdc_pkg::REG_NATIVE, 19'h3FFFF));
    rows.push_back(row_write(rpdc_pkg::REG_BAND, 19'd0));
    rows.push_back(row_poll(18'd300, 18'd260, 1'b1));
    // advance saturation with an oversized ring
    rows.push_back(row_write(rpdc_pkg::REG_RING, 19'h7FFFF));
    rows.push_back(row_poll(18'd0, 18'd0, 1'b1));
    rows.push_back(row_write(rpdc_pkg::REG_RING, 19'd1));
    rows.push_back(row_poll(18'd1, 18'd1, 1'b1));
    rows.push_back(row_poll(18'd0, 18'd0, 1'b1));
    rows.push_back(row_write(rpdc_pkg::REG_RING, 19'd0));
    rows.push_back(row_poll(18'd5, 18'd5, 1'b1));
    rows.push_back(row_poll(18'd2, 18'd2, 1'b1));
    rows.push_back(row_write(rpdc_pkg::REG_RING, 19'd262144));
    rows.push_back(row_poll(18'h3FFFF, 18'h3FFFF, 1'b1));
    rows.push_back(row_poll(18'd0, 18'd0, 1'b1));
    rows.push_back(row_write(REG_UNUSED, 19'h7FFFF));
    rows.push_back(row_write(rpdc_pkg::REG_TARGET, 19'h3FFFF));
    rows.push_back(row_poll(18'd40000, 18'd3, 1'b1));
    rows.push_back(row_write(rpdc_pkg::REG_TARGET, 19'd0));
    rows.push_back(row_poll(18'd40010, 18'd40000, 1'b1));
    rows.push_back(row_write(rpdc_pkg::REG_ENABLE, 19'd0));
    rows.push_back(row_poll(18'd123, 18'd456, 1'b1));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_write) begin
        settle();
        write_reg(rows[i].addr, rows[i].wdata);
      end else begin
        push_poll(rows[i].poll, rows[i].fixed, rows[i].want);
      end
    end

    settle();
    write_reg(rpdc_pkg::REG_ENABLE, 19'd1);
    write_reg(rpdc_pkg::REG_NATIVE, 19'd48000);
    write_reg(rpdc_pkg::REG_TARGET, 19'd2400);
    write_reg(rpdc_pkg::REG_BAND, 19'd48);
    write_reg(rpdc_pkg::REG_RING, 19'd48000);
    run_random(200, 1'b0);
    hold_ask++;
    run_random(210, 1'b0);

    settle();
    snd_idle = 68;
    rcv_idle = 25;
    write_reg(rpdc_pkg::REG_NATIVE, 19'd8000);
    write_reg(rpdc_pkg::REG_TARGET, CFG_DW'($urandom_range(0, 5000)));
    write_reg(rpdc_pkg::REG_BAND, 19'd0);
    write_reg(rpdc_pkg::REG_RING, 19'd262144);
    run_random(200, 1'b1);
    settle();
    run_random(210, 1'b1);

    settle();
    snd_idle = 0;
    rcv_idle = 0;
    write_reg(rpdc_pkg::REG_NATIVE, 19'd192000);
    write_reg(rpdc_pkg::REG_TARGET, CFG_DW'($urandom_range(0, 5000)));
    write_reg(rpdc_pkg::REG_BAND, CFG_DW'($urandom_range(0, 300)));
    write_reg(rpdc_pkg::REG_RING, CFG_DW'($urandom_range(1000, 262144)));
    run_random(410, 1'b1);

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
